/* src/kitt_pkg.sv */
// ----------------------------------------------------------------------------
// kitt_pkg
// Shared types and codes of the keyed interval timer table.
// ----------------------------------------------------------------------------
package kitt_pkg;

  localparam logic [2:0] CMD_SET   = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_MERGE = 3'd3;
  localparam logic [2:0] CMD_ABORT = 3'd4;
  localparam logic [2:0] CMD_CKPT  = 3'd5;
  localparam logic [2:0] CMD_CLEAR = 3'd6;
  localparam logic [2:0] CMD_READ  = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_STATE   = 2'd3;

  localparam logic [1:0] RUN_INVALID = 2'd0;
  localparam logic [1:0] RUN_INITED  = 2'd1;
  localparam logic [1:0] RUN_STARTED = 2'd2;
  localparam logic [1:0] RUN_STOPPED = 2'd3;

  typedef struct packed {
    logic [1:0]  run;
    logic [63:0] start_ts;
    logic [63:0] stop_ts;
    logic [63:0] total;
    logic [31:0] count;
    logic [31:0] sum;
  } rec_t;

  localparam rec_t REC_INIT = '{run: RUN_INITED, start_ts: 64'd0, stop_ts: 64'd0,
                                total: 64'd0, count: 32'd0, sum: 32'd0};

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_RD_T,
    S_RD_O,
    S_CALC,
    S_WB
  } kitt_state_e;

  typedef struct packed {
    logic cap;
    logic match;
    logic rd_o;
    logic load_t;
    logic calc;
    logic wb;
  } ctl_t;

endpackage

/* src/kitt_if.sv */
// ----------------------------------------------------------------------------
// kitt request and response channels
// Valid/ready channels carrying one request and one response.
// ----------------------------------------------------------------------------
interface kitt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] key;
  logic [31:0] other_key;
  logic [31:0] amount;
  logic [63:0] timestamp;

  modport source (output valid, cmd, key, other_key, amount, timestamp, input ready);
  modport sink   (input valid, cmd, key, other_key, amount, timestamp, output ready);
endinterface

interface kitt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] total_time;
  logic [31:0] stop_count;
  logic [31:0] accumulated;
  logic [1:0]  run_state;

  modport source (output valid, status, total_time, stop_count, accumulated, run_state,
                  input ready);
  modport sink   (input valid, status, total_time, stop_count, accumulated, run_state,
                  output ready);
endinterface

/* src/kitt_ctrl.sv */
// ----------------------------------------------------------------------------
// kitt_ctrl
// Sequencer: capture, match, two reads, compute, write back and respond.
// ----------------------------------------------------------------------------
module kitt_ctrl
  import kitt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output ctl_t ctl_o
);

  kitt_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ctl_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.cap = 1'b1;
          state_d   = S_MATCH;
        end
      end
      S_MATCH: begin
        ctl_o.match = 1'b1;
        state_d     = S_RD_T;
      end
      S_RD_T: begin
        state_d = S_RD_O;
      end
      S_RD_O: begin
        ctl_o.rd_o   = 1'b1;
        ctl_o.load_t = 1'b1;
        state_d      = S_CALC;
      end
      S_CALC: begin
        ctl_o.calc = 1'b1;
        state_d    = S_WB;
      end
      S_WB: begin
        // hold until the response register is free
        if (!out_valid_q || out_ready_i) begin
          ctl_o.wb    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/kitt_dp.sv */
// ----------------------------------------------------------------------------
// kitt_dp
// Key match, entry memory, timer arithmetic and response register.
// ----------------------------------------------------------------------------
module kitt_dp
  import kitt_pkg::*;
#(
  parameter int ENTRIES = 64,
  parameter int IW      = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_t        ctl_i,
  input  logic [2:0]  cmd_i,
  input  logic [31:0] key_i,
  input  logic [31:0] other_key_i,
  input  logic [31:0] amount_i,
  input  logic [63:0] timestamp_i,
  output logic [1:0]  status_o,
  output logic [63:0] total_time_o,
  output logic [31:0] stop_count_o,
  output logic [31:0] accumulated_o,
  output logic [1:0]  run_state_o
);

  logic [ENTRIES-1:0] valid_q, fresh_q;
  logic [31:0]        keys_q [ENTRIES];
  rec_t               mem [ENTRIES];

  logic [2:0]  cmd_q;
  logic [31:0] key_q, okey_q, amt_q;
  logic [63:0] now_q;

  logic          hit_t_q, hit_o_q, full_q;
  logic [IW-1:0] idx_t_q, idx_o_q, free_q;
  logic          hit_t_d, hit_o_d, full_d;
  logic [IW-1:0] idx_t_d, idx_o_d, free_d;

  logic [IW-1:0] raddr;
  rec_t          rdata_q, t_q, o_q, eff;
  logic          frd_q;
  logic [63:0]   elapsed_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap) begin
      cmd_q  <= cmd_i;
      key_q  <= key_i;
      okey_q <= other_key_i;
      amt_q  <= amount_i;
      now_q  <= timestamp_i;
    end
  end

  // parallel key compare; lowest matching and lowest free entry win
  always_comb begin
    hit_t_d = 1'b0;
    hit_o_d = 1'b0;
    full_d  = 1'b1;
    idx_t_d = '0;
    idx_o_d = '0;
    free_d  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && keys_q[i] == key_q) begin
        hit_t_d = 1'b1;
        idx_t_d = IW'(i);
      end
      if (valid_q[i] && keys_q[i] == okey_q) begin
        hit_o_d = 1'b1;
        idx_o_d = IW'(i);
      end
      if (!valid_q[i]) begin
        full_d = 1'b0;
        free_d = IW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.match) begin
      hit_t_q <= hit_t_d;
      hit_o_q <= hit_o_d;
      full_q  <= full_d;
      idx_t_q <= idx_t_d;
      idx_o_q <= idx_o_d;
      free_q  <= free_d;
    end
  end

  assign raddr = ctl_i.rd_o ? idx_o_q : idx_t_q;
  assign eff   = frd_q ? REC_INIT : rdata_q;

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr];
    frd_q   <= fresh_q[raddr];
    if (ctl_i.load_t) begin
      t_q <= eff;
    end
    if (ctl_i.calc) begin
      o_q       <= eff;
      elapsed_q <= now_q - t_q.start_ts;
    end
  end

  // write-back decision
  rec_t       nr, rec_out;
  logic       wr, show, alloc, set_fresh, clr_all;
  logic [1:0] st;

  always_comb begin
    nr        = t_q;
    rec_out   = t_q;
    wr        = 1'b0;
    show      = hit_t_q;
    alloc     = 1'b0;
    set_fresh = 1'b0;
    clr_all   = 1'b0;
    st        = ST_OK;
    unique case (cmd_q)
      CMD_SET: begin
        if (hit_t_q) begin
          set_fresh = 1'b1;
          rec_out   = REC_INIT;
        end else if (full_q) begin
          st = ST_FULL;
        end else begin
          alloc   = 1'b1;
          show    = 1'b1;
          rec_out = REC_INIT;
        end
      end
      CMD_START: begin
        if (!hit_t_q) st = ST_UNKNOWN;
        else if (t_q.run == RUN_STARTED) st = ST_STATE;
        else begin
          nr.start_ts = now_q;
          nr.run      = RUN_STARTED;
          wr          = 1'b1;
        end
      end
      CMD_STOP: begin
        if (!hit_t_q) st = ST_UNKNOWN;
        else if (t_q.run == RUN_STARTED) begin
          nr.stop_ts = now_q;
          nr.total   = t_q.total + elapsed_q;
          nr.count   = t_q.count + 32'd1;
          nr.sum     = t_q.sum + amt_q;
          nr.run     = RUN_STOPPED;
          wr         = 1'b1;
        end else if (t_q.run != RUN_STOPPED) st = ST_STATE;
      end
      CMD_MERGE: begin
        if (!hit_t_q || !hit_o_q) begin
          st   = ST_UNKNOWN;
          show = 1'b0;
        end else begin
          nr.total = t_q.total + o_q.total;
          nr.count = t_q.count + o_q.count;
          nr.sum   = t_q.sum + o_q.sum;
          wr       = 1'b1;
        end
      end
      CMD_ABORT: begin
        if (!hit_t_q) st = ST_UNKNOWN;
        else begin
          nr.run = RUN_STOPPED;
          wr     = 1'b1;
        end
      end
      CMD_CKPT: begin
        if (!hit_t_q) st = ST_UNKNOWN;
        else if (t_q.run == RUN_STARTED) begin
          nr.stop_ts  = now_q;
          nr.start_ts = now_q;
          nr.total    = t_q.total + elapsed_q;
          nr.count    = t_q.count + 32'd1;
          wr          = 1'b1;
        end else if (t_q.run == RUN_STOPPED) begin
          nr.start_ts = t_q.stop_ts;
          wr          = 1'b1;
        end else st = ST_STATE;
      end
      CMD_CLEAR: begin
        clr_all = 1'b1;
        rec_out = REC_INIT;
      end
      CMD_READ: begin
        if (!hit_t_q) st = ST_UNKNOWN;
      end
    endcase
    if (wr) rec_out = nr;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wb && wr) begin
      mem[idx_t_q] <= nr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wb && alloc) begin
      keys_q[free_q] <= key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fresh_q <= '0;
    end else if (ctl_i.wb) begin
      if (clr_all) fresh_q <= '1;
      if (set_fresh) fresh_q[idx_t_q] <= 1'b1;
      if (wr) fresh_q[idx_t_q] <= 1'b0;
      if (alloc) begin
        valid_q[free_q] <= 1'b1;
        fresh_q[free_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wb) begin
      status_o      <= st;
      total_time_o  <= show ? rec_out.total : 64'd0;
      stop_count_o  <= show ? rec_out.count : 32'd0;
      accumulated_o <= show ? rec_out.sum : 32'd0;
      run_state_o   <= show ? rec_out.run : RUN_INVALID;
    end
  end

endmodule

/* src/keyed_interval_timer_table_core.sv */
// ----------------------------------------------------------------------------
// keyed_interval_timer_table_core
// Table of keyed interval timers with set, start, stop, merge and read.
// ----------------------------------------------------------------------------
// One request is in flight at a time. The response register is loaded at
// write-back; a request passes from the idle state in which it is taken
// through key match across all entries, two reads of the single ported
// entry memory (target, then merge source), the elapsed-time subtract and
// the write-back with its 64-bit add. The next request is taken in the cycle
// after write-back, even while the previous response still waits;
// its write-back then stalls until that response has been taken.
// Keys and valid bits sit in flip-flops; every entry also has a "fresh" flag
// so that set and clear all reinitialise entries without touching memory.
// Reset is immediate; no clearing pass is needed.
module keyed_interval_timer_table_core
  import kitt_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  kitt_req_if.sink   req_i,
  kitt_rsp_if.source rsp_o
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  ctl_t ctl;

  // sequence one request through match, read, compute and write back
  kitt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .ctl_o       (ctl)
  );

  kitt_dp #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .cmd_i         (req_i.cmd),
    .key_i         (req_i.key),
    .other_key_i   (req_i.other_key),
    .amount_i      (req_i.amount),
    .timestamp_i   (req_i.timestamp),
    .status_o      (rsp_o.status),
    .total_time_o  (rsp_o.total_time),
    .stop_count_o  (rsp_o.stop_count),
    .accumulated_o (rsp_o.accumulated),
    .run_state_o   (rsp_o.run_state)
  );

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while another is in flight");

  a_rsp_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(ctl.wb))
    else $error("response raised without write-back");

  a_wb_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.wb |-> (!rsp_o.valid || rsp_o.ready))
    else $error("write-back overwrote a pending response");
`endif

endmodule

/* tb/keyed_interval_timer_table_core_test.sv */
// ----------------------------------------------------------------------------
// keyed_interval_timer_table_core_test
// Drives timer commands through the request channel and compares every
// response with a behavioural timer table kept alongside the block.
// ----------------------------------------------------------------------------
module keyed_interval_timer_table_core_test;
  import kitt_pkg::*;

  localparam int ENTRIES = 64;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] total_time;
    logic [31:0] stop_count;
    logic [31:0] accumulated;
    logic [1:0]  run_state;
  } timer_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  kitt_req_if req_if ();
  kitt_rsp_if rsp_if ();

  keyed_interval_timer_table_core #(.ENTRIES(ENTRIES)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  always #10 clk_i = ~clk_i;

  // Behavioural copy of the table
  logic        tbl_valid [ENTRIES];
  logic [31:0] tbl_key   [ENTRIES];
  logic [1:0]  tbl_run   [ENTRIES];
  logic [63:0] tbl_start [ENTRIES];
  logic [63:0] tbl_end   [ENTRIES];
  logic [63:0] tbl_total [ENTRIES];
  logic [31:0] tbl_count [ENTRIES];
  logic [31:0] tbl_sum   [ENTRIES];

  timer_rsp_t expected_rsps[$];
  int  errors = 0;
  bit  idle_en = 1'b1;
  bit  hold_rsp = 1'b0;
  int unsigned rsp_idle_cnt = 0;
  logic [63:0] now_ts = 64'd0;
  logic [31:0] key_pool[8];

  function automatic int find_timer(logic [31:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void init_timer(int i);
    tbl_run[i] = RUN_INITED;
    tbl_start[i] = '0;
    tbl_end[i] = '0;
    tbl_total[i] = '0;
    tbl_count[i] = '0;
    tbl_sum[i] = '0;
  endfunction

  function automatic void close_interval(int i, logic [63:0] ts, logic [31:0] amt);
    tbl_end[i] = ts;
    tbl_total[i] = tbl_total[i] + (ts - tbl_start[i]);
    tbl_count[i] = tbl_count[i] + 32'd1;
    tbl_sum[i] = tbl_sum[i] + amt;
  endfunction

  // Apply one command to the table copy and return the response it gives
  function automatic timer_rsp_t apply_timer_cmd(logic [2:0] cmd, logic [31:0] k,
                                                 logic [31:0] k2, logic [31:0] amt,
                                                 logic [63:0] ts);
    timer_rsp_t r;
    int t, o, f;
    r = '0;
    r.status = ST_OK;
    t = find_timer(k);
    case (cmd)
      CMD_SET: begin
        if (t < 0) begin
          f = -1;
          for (int i = ENTRIES - 1; i >= 0; i--) if (!tbl_valid[i]) f = i;
          if (f < 0) r.status = ST_FULL;
          else begin
            tbl_valid[f] = 1'b1;
            tbl_key[f] = k;
            init_timer(f);
            t = f;
          end
        end else init_timer(t);
      end
      CMD_START: begin
        if (t < 0) r.status = ST_UNKNOWN;
        else if (tbl_run[t] == RUN_STARTED) r.status = ST_STATE;
        else begin
          tbl_start[t] = ts;
          tbl_run[t] = RUN_STARTED;
        end
      end
      CMD_STOP: begin
        if (t < 0) r.status = ST_UNKNOWN;
        else if (tbl_run[t] == RUN_STARTED) begin
          close_interval(t, ts, amt);
          tbl_run[t] = RUN_STOPPED;
        end else if (tbl_run[t] != RUN_STOPPED) r.status = ST_STATE;
      end
      CMD_MERGE: begin
        o = find_timer(k2);
        if (t < 0 || o < 0) begin
          r.status = ST_UNKNOWN;
          t = -1;
        end else begin
          tbl_total[t] = tbl_total[t] + tbl_total[o];
          tbl_count[t] = tbl_count[t] + tbl_count[o];
          tbl_sum[t] = tbl_sum[t] + tbl_sum[o];
        end
      end
      CMD_ABORT: begin
        if (t < 0) r.status = ST_UNKNOWN;
        else tbl_run[t] = RUN_STOPPED;
      end
      CMD_CKPT: begin
        if (t < 0) r.status = ST_UNKNOWN;
        else if (tbl_run[t] == RUN_STARTED) begin
          close_interval(t, ts, 32'd0);
          tbl_start[t] = tbl_end[t];
        end else if (tbl_run[t] == RUN_STOPPED) tbl_start[t] = tbl_end[t];
        else r.status = ST_STATE;
      end
      CMD_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) if (tbl_valid[i]) init_timer(i);
      end
      default: begin
        if (t < 0) r.status = ST_UNKNOWN;
      end
    endcase
    if (t >= 0) begin
      r.total_time = tbl_total[t];
      r.stop_count = tbl_count[t];
      r.accumulated = tbl_sum[t];
      r.run_state = tbl_run[t];
    end
    return r;
  endfunction

  // Offer one request, hold it until accepted, then log its expected response.
  // Valid stays high after acceptance unless an idle gap follows; the block
  // is busy until its write-back, so the old request is not taken again.
  task automatic send_request(logic [2:0] cmd, logic [31:0] k, logic [31:0] k2,
                              logic [31:0] amt, logic [63:0] ts);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.cmd <= cmd;
    req_if.key <= k;
    req_if.other_key <= k2;
    req_if.amount <= amt;
    req_if.timestamp <= ts;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    expected_rsps.push_back(apply_timer_cmd(cmd, k, k2, amt, ts));
  endtask

  // Timestamps mostly advance, sometimes jump or wrap
  function automatic logic [63:0] next_ts();
    case ($urandom_range(0, 9))
      0: now_ts = {$urandom, $urandom};
      1: now_ts = now_ts - 64'($urandom_range(0, 200));
      default: now_ts = now_ts + 64'($urandom_range(0, 200));
    endcase
    return now_ts;
  endfunction

  function automatic logic [31:0] pick_key();
    return ($urandom_range(0, 15) == 0) ? $urandom : key_pool[$urandom_range(0, 7)];
  endfunction

  // Response side: random idle bursts, long hold on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rsp_idle_cnt <= 0;
    end else if (hold_rsp) begin
      rsp_if.ready <= 1'b0;
    end else if (rsp_idle_cnt != 0) begin
      rsp_if.ready <= 1'b0;
      rsp_idle_cnt <= rsp_idle_cnt - 1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      rsp_if.ready <= 1'b0;
      rsp_idle_cnt <= $urandom_range(0, 14);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Compare each accepted response with the oldest expectation
  always @(posedge clk_i) begin
    timer_rsp_t exp_r, act_r;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      act_r = '{rsp_if.status, rsp_if.total_time, rsp_if.stop_count,
                rsp_if.accumulated, rsp_if.run_state};
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected response %h", $time, act_r);
        errors++;
      end else begin
        exp_r = expected_rsps.pop_front();
        if (act_r !== exp_r) begin
          $display("%0t: expected %h actual %h", $time, exp_r, act_r);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_request(CMD_READ, 32'h0, 32'h0, 32'h0, 64'h0);
    send_request(CMD_SET, 32'h0, 32'h0, 32'h0, 64'h0);
    send_request(CMD_SET, 32'hffff_ffff, 32'h0, 32'h0, 64'h0);
    send_request(CMD_STOP, 32'h0, 32'h0, 32'h5, 64'h10);
    send_request(CMD_CKPT, 32'h0, 32'h0, 32'h0, 64'h10);
    send_request(CMD_START, 32'h0, 32'h0, 32'h0, 64'hffff_ffff_ffff_fff0);
    send_request(CMD_START, 32'h0, 32'h0, 32'h0, 64'h1);
    send_request(CMD_CKPT, 32'h0, 32'h0, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
    send_request(CMD_STOP, 32'h0, 32'h0, 32'hffff_ffff, 64'h20);
    send_request(CMD_STOP, 32'h0, 32'h0, 32'h1, 64'h30);
    send_request(CMD_CKPT, 32'h0, 32'h0, 32'h0, 64'h40);
    send_request(CMD_START, 32'hffff_ffff, 32'h0, 32'h0, 64'h7);
    send_request(CMD_STOP, 32'hffff_ffff, 32'h0, 32'hffff_ffff, 64'h7);
    send_request(CMD_MERGE, 32'h0, 32'hffff_ffff, 32'h0, 64'h0);
    send_request(CMD_MERGE, 32'h0, 32'h0, 32'h0, 64'h0);
    send_request(CMD_MERGE, 32'h0, 32'h1234, 32'h0, 64'h0);
    send_request(CMD_ABORT, 32'h1234, 32'h0, 32'h0, 64'h0);
    send_request(CMD_ABORT, 32'hffff_ffff, 32'h0, 32'h0, 64'h0);
    send_request(CMD_READ, 32'h0, 32'h0, 32'h0, 64'h0);
    send_request(CMD_CLEAR, 32'h0, 32'h0, 32'h0, 64'h0);
    send_request(CMD_CLEAR, 32'h5555, 32'h0, 32'h0, 64'h0);
  endtask

  // Set new keys until the table is full and beyond, then start one of them
  task automatic test_table_full();
    for (int i = 0; i < ENTRIES; i++)
      send_request(CMD_SET, 32'h1000 + i, 32'h0, 32'h0, 64'h0);
    send_request(CMD_SET, 32'hdead_0000, 32'h0, 32'h0, 64'h0);
    send_request(CMD_START, 32'h1005, 32'h0, 32'h0, 64'h0);
  endtask

  // Hold the response side off while requests keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_rsp = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_rsp = 1'b0;
      end
      for (int i = 0; i < 20; i++)
        send_request(CMD_READ, 32'h1000 + i, 32'h0, 32'h0, 64'h0);
    join
  endtask

  // Mostly well-formed set/start/stop lifecycles over a small key pool
  task automatic test_random(int n);
    logic [2:0] cmd;
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      if (i == n - 200) idle_en = 1'b0;
      k = pick_key();
      case ($urandom_range(0, 19))
        0, 1, 2:     cmd = CMD_SET;
        3, 4, 5, 6:  cmd = CMD_START;
        7, 8, 9, 10: cmd = CMD_STOP;
        11, 12:      cmd = CMD_MERGE;
        13:          cmd = CMD_ABORT;
        14, 15:      cmd = CMD_CKPT;
        16:          cmd = ($urandom_range(0, 3) == 0) ? CMD_CLEAR : CMD_READ;
        default:     cmd = 3'($urandom_range(0, 7));
      endcase
      send_request(cmd, k, pick_key(), $urandom, next_ts());
    end
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.cmd = CMD_READ;
    req_if.key = '0;
    req_if.other_key = '0;
    req_if.amount = '0;
    req_if.timestamp = '0;
    for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
    for (int i = 0; i < 8; i++) key_pool[i] = (i < 2) ? {32{i[0]}} : $urandom;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_backpressure();
    // Reinitialise every entry; clear keeps all entries valid, so the table stays full
    send_request(CMD_CLEAR, 32'h0, 32'h0, 32'h0, 64'h0);
    test_random(1600);
    req_if.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("keyed_interval_timer_table_core: match");
    else $display("keyed_interval_timer_table_core: mismatch");
    $finish;
  end

  initial begin
    #10000000;
    $display("keyed_interval_timer_table_core: mismatch");
    $finish;
  end

endmodule
